FILE: sv/lsmp_pkg.sv
// Shared types and constants for the linear sieve block.
// Used by lsmp_core and linear_sieve_min_prime_power; no dependencies.
package lsmp_pkg;

  localparam int MAX_N      = 65535;
  localparam int MAX_PRIMES = 8192;
  localparam int NUM_W      = 16;
  localparam int PIDX_W     = $clog2(MAX_PRIMES);
  localparam int PCNT_W     = 14;
  localparam int ENT_W      = 2 * NUM_W;

  localparam logic [1:0] CMD_BUILD = 2'd0;
  localparam logic [1:0] CMD_NUM   = 2'd1;
  localparam logic [1:0] CMD_PRIME = 2'd2;

  localparam logic [1:0] STAT_BUILD = 2'd0;
  localparam logic [1:0] STAT_NUM   = 2'd1;
  localparam logic [1:0] STAT_PRIME = 2'd2;
  localparam logic [1:0] STAT_ERR   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD_I,
    S_CHK_I,
    S_RD_P,
    S_MUL,
    S_WR,
    S_DONE,
    S_Q_NUM,
    S_Q_PRM
  } state_t;

  typedef struct packed {
    logic              we;
    logic [NUM_W-1:0]  waddr;
    logic [ENT_W-1:0]  wdata;
    logic [NUM_W-1:0]  raddr;
  } num_req_t;

  typedef struct packed {
    logic              we;
    logic [PIDX_W-1:0] waddr;
    logic [NUM_W-1:0]  wdata;
    logic [PIDX_W-1:0] raddr;
  } prm_req_t;

  typedef struct packed {
    logic              vld;
    logic [1:0]        status;
    logic [NUM_W-1:0]  min_factor;
    logic [NUM_W-1:0]  min_power;
    logic              is_prime;
    logic [NUM_W-1:0]  prime_value;
    logic [PCNT_W-1:0] prime_count;
  } res_t;

endpackage

FILE: sv/linear_sieve_min_prime_power.sv
// Linear sieve with smallest prime factor and its full power per number.
// Number or k-th prime query: table read at start, answer registered. Rejected query
// or unused command: answered from idle. Build: clears the number table, then sieves
// each number over the primes. One item at a time; a new item is taken once busy falls.
// Synchronous active-low reset; results cannot be stalled.
// Depends on lsmp_pkg, lsmp_core and lsmp_ram.
module linear_sieve_min_prime_power (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic [lsmp_pkg::NUM_W-1:0]  in_index,
  input  logic                        cfg_we,
  input  logic [lsmp_pkg::NUM_W-1:0]  cfg_wdata,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [lsmp_pkg::NUM_W-1:0]  out_min_factor,
  output logic [lsmp_pkg::NUM_W-1:0]  out_min_power,
  output logic                        out_is_prime,
  output logic [lsmp_pkg::NUM_W-1:0]  out_prime_value,
  output logic [lsmp_pkg::PCNT_W-1:0] out_prime_count
);
  import lsmp_pkg::*;

  num_req_t         num_req;
  prm_req_t         prm_req;
  logic [ENT_W-1:0] num_rdata;
  logic [NUM_W-1:0] prm_rdata;
  res_t             res;
  logic             valid_r;
  res_t             res_r;

  lsmp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_index   (in_index),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .num_req    (num_req),
    .num_rdata  (num_rdata),
    .prm_req    (prm_req),
    .prm_rdata  (prm_rdata),
    .res        (res)
  );

  lsmp_ram #(.ADDR_W(NUM_W), .DATA_W(ENT_W)) u_num_ram (
    .clk   (clk),
    .we    (num_req.we),
    .waddr (num_req.waddr),
    .wdata (num_req.wdata),
    .raddr (num_req.raddr),
    .rdata (num_rdata)
  );

  lsmp_ram #(.ADDR_W(PIDX_W), .DATA_W(NUM_W)) u_prm_ram (
    .clk   (clk),
    .we    (prm_req.we),
    .waddr (prm_req.waddr),
    .wdata (prm_req.wdata),
    .raddr (prm_req.raddr),
    .rdata (prm_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= res.vld;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res;
  end

  assign out_valid       = valid_r;
  assign out_status      = res_r.status;
  assign out_min_factor  = res_r.min_factor;
  assign out_min_power   = res_r.min_power;
  assign out_is_prime    = res_r.is_prime;
  assign out_prime_value = res_r.prime_value;
  assign out_prime_count = res_r.prime_count;

endmodule

FILE: sv/lsmp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lsmp_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/lsmp_core.sv
// Sieve sequencer and query logic: clears and fills the number table, keeps the
// prime list and answers queries. Depends on lsmp_pkg; memories sit outside.
module lsmp_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_command,
  input  logic [lsmp_pkg::NUM_W-1:0] in_index,
  input  logic                     cfg_we,
  input  logic [lsmp_pkg::NUM_W-1:0] cfg_wdata,
  output lsmp_pkg::num_req_t       num_req,
  input  logic [lsmp_pkg::ENT_W-1:0] num_rdata,
  output lsmp_pkg::prm_req_t       prm_req,
  input  logic [lsmp_pkg::NUM_W-1:0] prm_rdata,
  output lsmp_pkg::res_t           res
);
  import lsmp_pkg::*;

  state_t            state_r, state_nxt;
  logic [NUM_W-1:0]  limit_r, limit_nxt;
  logic [NUM_W-1:0]  top_r, top_nxt;
  logic [NUM_W-1:0]  addr_r, addr_nxt;
  logic [NUM_W-1:0]  i_r, i_nxt;
  logic [PCNT_W-1:0] j_r, j_nxt;
  logic [PCNT_W-1:0] pf_r, pf_nxt;
  logic [NUM_W-1:0]  f_r, f_nxt;
  logic [NUM_W-1:0]  pw_r, pw_nxt;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [ENT_W-1:0]  t_r, t_nxt;
  logic [NUM_W-1:0]  pp_r, pp_nxt;
  logic              built_r, built_nxt;
  logic [NUM_W-1:0]  blim_r, blim_nxt;
  logic [NUM_W-1:0]  qidx_r, qidx_nxt;

  logic              accept;
  logic              num_ok;
  logic              prm_ok;
  logic [NUM_W-1:0]  top_clamp;
  logic [NUM_W-1:0]  rd_f;
  logic [NUM_W-1:0]  rd_pw;
  logic              t_over;
  logic              hit;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign num_ok    = built_r && (in_index != '0) && (in_index <= blim_r);
  assign prm_ok    = built_r && (in_index != '0) && (in_index <= {2'b00, pf_r});
  assign top_clamp = (32'(limit_r) > MAX_N) ? NUM_W'(MAX_N) : limit_r;
  assign rd_f      = num_rdata[ENT_W-1:NUM_W];
  assign rd_pw     = num_rdata[NUM_W-1:0];
  assign t_over    = (t_r > ENT_W'(top_r));
  assign hit       = (q_r == f_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_BUILD: state_nxt = S_CLEAR;
            CMD_NUM:   state_nxt = num_ok ? S_Q_NUM : S_IDLE;
            CMD_PRIME: state_nxt = prm_ok ? S_Q_PRM : S_IDLE;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLEAR: begin
        if (addr_r == top_r) begin
          state_nxt = (top_r >= NUM_W'(2)) ? S_RD_I : S_DONE;
        end
      end
      S_RD_I: state_nxt = S_CHK_I;
      S_CHK_I: begin
        if (rd_f == '0 && 32'(pf_r) >= MAX_PRIMES) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD_P;
        end
      end
      S_RD_P: begin
        if (j_r < pf_r) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = (i_r == top_r) ? S_DONE : S_RD_I;
        end
      end
      S_MUL: state_nxt = S_WR;
      S_WR: begin
        if (t_over || hit) begin
          state_nxt = (i_r == top_r) ? S_DONE : S_RD_I;
        end else begin
          state_nxt = S_RD_P;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      S_Q_NUM: state_nxt = S_IDLE;
      S_Q_PRM: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    limit_nxt = cfg_we ? cfg_wdata : limit_r;
    top_nxt   = top_r;
    addr_nxt  = addr_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    pf_nxt    = pf_r;
    f_nxt     = f_r;
    pw_nxt    = pw_r;
    q_nxt     = q_r;
    t_nxt     = t_r;
    pp_nxt    = pp_r;
    built_nxt = built_r;
    blim_nxt  = blim_r;
    qidx_nxt  = qidx_r;

    num_req       = '0;
    prm_req       = '0;
    res           = '0;
    res.prime_count = pf_r;

    case (state_r)
      S_IDLE: begin
        qidx_nxt      = in_index;
        num_req.raddr = in_index;
        prm_req.raddr = PIDX_W'(in_index - NUM_W'(1));
        if (accept) begin
          case (in_command)
            CMD_BUILD: begin
              top_nxt  = top_clamp;
              addr_nxt = '0;
              pf_nxt   = '0;
              i_nxt    = NUM_W'(2);
            end
            CMD_NUM: begin
              res.vld    = !num_ok;
              res.status = STAT_ERR;
            end
            CMD_PRIME: begin
              res.vld    = !prm_ok;
              res.status = STAT_ERR;
            end
            default: begin
              res.vld    = 1'b1;
              res.status = STAT_ERR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        num_req.we    = 1'b1;
        num_req.waddr = addr_r;
        num_req.wdata = (addr_r == NUM_W'(1)) ? {NUM_W'(1), NUM_W'(1)} : '0;
        addr_nxt      = addr_r + NUM_W'(1);
      end
      S_RD_I: begin
        num_req.raddr = i_r;
      end
      S_CHK_I: begin
        j_nxt = '0;
        if (rd_f == '0) begin
          if (32'(pf_r) >= MAX_PRIMES) begin
            top_nxt = i_r - NUM_W'(1);
          end else begin
            num_req.we    = 1'b1;
            num_req.waddr = i_r;
            num_req.wdata = {i_r, i_r};
            prm_req.we    = 1'b1;
            prm_req.waddr = pf_r[PIDX_W-1:0];
            prm_req.wdata = i_r;
            pf_nxt        = pf_r + PCNT_W'(1);
            f_nxt         = i_r;
            pw_nxt        = i_r;
          end
        end else begin
          f_nxt  = rd_f;
          pw_nxt = rd_pw;
        end
      end
      S_RD_P: begin
        prm_req.raddr = j_r[PIDX_W-1:0];
        if (j_r >= pf_r) begin
          i_nxt = i_r + NUM_W'(1);
        end
      end
      S_MUL: begin
        q_nxt  = prm_rdata;
        t_nxt  = ENT_W'(i_r) * ENT_W'(prm_rdata);
        pp_nxt = NUM_W'(pw_r * prm_rdata);
      end
      S_WR: begin
        if (t_over) begin
          i_nxt = i_r + NUM_W'(1);
        end else begin
          num_req.we    = 1'b1;
          num_req.waddr = t_r[NUM_W-1:0];
          num_req.wdata = {q_r, hit ? pp_r : q_r};
          if (hit) begin
            i_nxt = i_r + NUM_W'(1);
          end else begin
            j_nxt = j_r + PCNT_W'(1);
          end
        end
      end
      S_DONE: begin
        built_nxt  = 1'b1;
        blim_nxt   = top_r;
        res.vld    = 1'b1;
        res.status = STAT_BUILD;
      end
      S_Q_NUM: begin
        res.vld        = 1'b1;
        res.status     = STAT_NUM;
        res.min_factor = rd_f;
        res.min_power  = rd_pw;
        res.is_prime   = (qidx_r > NUM_W'(1)) && (rd_f == qidx_r);
      end
      S_Q_PRM: begin
        res.vld         = 1'b1;
        res.status      = STAT_PRIME;
        res.prime_value = prm_rdata;
      end
      default: begin
        res.vld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= NUM_W'(MAX_N);
      pf_r    <= '0;
      built_r <= 1'b0;
      blim_r  <= '0;
      top_r   <= '0;
      addr_r  <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      pf_r    <= pf_nxt;
      built_r <= built_nxt;
      blim_r  <= blim_nxt;
      top_r   <= top_nxt;
      addr_r  <= addr_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r    <= f_nxt;
    pw_r   <= pw_nxt;
    q_r    <= q_nxt;
    t_r    <= t_nxt;
    pp_r   <= pp_nxt;
    qidx_r <= qidx_nxt;
  end

endmodule

FILE: bench/linear_sieve_min_prime_power_test.sv
// Self-checking bench for linear_sieve_min_prime_power: directed and random command
// sessions, each answer compared against an in-bench linear sieve predictor.
// Depends on lsmp_pkg and the linear_sieve_min_prime_power RTL only.
module linear_sieve_min_prime_power_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lsmp_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 4_000_000;
  localparam int REPORT_MAX   = 10;
  localparam int RANDOM_ITEMS = 1450;
  localparam int TOTAL_ITEMS  = 1750;

  typedef struct packed {
    logic [1:0]        status;
    logic [NUM_W-1:0]  min_factor;
    logic [NUM_W-1:0]  min_power;
    logic              is_prime;
    logic [NUM_W-1:0]  prime_value;
    logic [PCNT_W-1:0] prime_count;
  } answer_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_command = CMD_BUILD;
  logic [NUM_W-1:0]  in_index = '0;
  logic              cfg_we = 1'b0;
  logic [NUM_W-1:0]  cfg_wdata = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [NUM_W-1:0]  out_min_factor;
  logic [NUM_W-1:0]  out_min_power;
  logic              out_is_prime;
  logic [NUM_W-1:0]  out_prime_value;
  logic [PCNT_W-1:0] out_prime_count;

  linear_sieve_min_prime_power dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_index        (in_index),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_min_factor  (out_min_factor),
    .out_min_power   (out_min_power),
    .out_is_prime    (out_is_prime),
    .out_prime_value (out_prime_value),
    .out_prime_count (out_prime_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  logic [NUM_W-1:0] spf_tab   [0:MAX_N];
  logic [NUM_W-1:0] pow_tab   [0:MAX_N];
  logic [NUM_W-1:0] prime_tab [0:MAX_PRIMES-1];
  int      prime_cnt = 0;
  bit      sieve_built = 1'b0;
  int      covered_top = 0;
  int      limit_reg = 65535;
  answer_t pending_answers[$];
  int      fail_count = 0;
  int      items_sent = 0;
  int      quiet_cycles = 0;

  function automatic void run_sieve();
    int     top;
    int     i;
    int     j;
    int     q;
    longint t;
    top = (limit_reg > MAX_N) ? MAX_N : limit_reg;
    prime_cnt = 0;
    for (i = 0; i <= top; i++) begin
      spf_tab[i] = '0;
      pow_tab[i] = '0;
    end
    if (top >= 1) begin
      spf_tab[1] = NUM_W'(1);
      pow_tab[1] = NUM_W'(1);
    end
    for (i = 2; i <= top; i++) begin
      if (spf_tab[i] == 0) begin
        if (prime_cnt >= MAX_PRIMES) begin
          top = i - 1;
          break;
        end
        prime_tab[prime_cnt] = NUM_W'(i);
        prime_cnt++;
        spf_tab[i] = NUM_W'(i);
        pow_tab[i] = NUM_W'(i);
      end
      for (j = 0; j < prime_cnt; j++) begin
        q = int'(prime_tab[j]);
        t = longint'(i) * q;
        if (t > top) break;
        spf_tab[t] = NUM_W'(q);
        if (i % q == 0) begin
          pow_tab[t] = NUM_W'(int'(pow_tab[i]) * q);
          break;
        end
        pow_tab[t] = NUM_W'(q);
      end
    end
    covered_top = top;
    sieve_built = 1'b1;
  endfunction

  function automatic answer_t sieve_answer(logic [1:0] cmd, logic [NUM_W-1:0] idx);
    answer_t a;
    a = '0;
    a.status = STAT_ERR;
    case (cmd)
      CMD_BUILD: begin
        run_sieve();
        a.status = STAT_BUILD;
      end
      CMD_NUM: begin
        if (sieve_built && idx >= 1 && idx <= covered_top) begin
          a.status = STAT_NUM;
          a.min_factor = spf_tab[idx];
          a.min_power = pow_tab[idx];
          a.is_prime = (idx > 1 && spf_tab[idx] == idx);
        end
      end
      CMD_PRIME: begin
        if (sieve_built && idx >= 1 && idx <= prime_cnt) begin
          a.status = STAT_PRIME;
          a.prime_value = prime_tab[idx - 1];
        end
      end
      default: ;
    endcase
    a.prime_count = PCNT_W'(prime_cnt);
    return a;
  endfunction

  function automatic logic [NUM_W-1:0] pick_index(int top);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return NUM_W'(top);
    if (r == 2) return NUM_W'(top + 1);
    if (top < 1) return NUM_W'($urandom_range(0, 3));
    return NUM_W'($urandom_range(1, top));
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [NUM_W-1:0] idx,
                           input bit gaps);
    answer_t want;
    start <= 1'b1;
    in_command <= cmd;
    in_index <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    want = sieve_answer(cmd, idx);
    pending_answers = {pending_answers, want};
    items_sent++;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [NUM_W-1:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    limit_reg = int'(value);
    cfg_we <= 1'b0;
  endtask

  task automatic test_prebuild_errors();
    send_item(CMD_NUM, 16'd5, 1'b1);
    send_item(CMD_PRIME, 16'd1, 1'b1);
    send_item(CMD_UNUSED, 16'hFFFF, 1'b1);
  endtask

  task automatic test_full_range();
    write_limit(16'hFFFF);
    send_item(CMD_BUILD, 16'hFFFF, 1'b1);
    send_item(CMD_NUM, 16'd0, 1'b1);
    send_item(CMD_NUM, 16'd1, 1'b1);
    send_item(CMD_NUM, 16'd32768, 1'b1);
    send_item(CMD_NUM, 16'd59049, 1'b1);
    send_item(CMD_NUM, 16'd65521, 1'b1);
    send_item(CMD_NUM, 16'd65535, 1'b1);
    send_item(CMD_PRIME, 16'd0, 1'b1);
    send_item(CMD_PRIME, 16'd1, 1'b1);
    send_item(CMD_PRIME, 16'd6542, 1'b1);
    send_item(CMD_PRIME, 16'd6543, 1'b1);
    send_item(CMD_UNUSED, 16'd0, 1'b1);
  endtask

  task automatic test_stale_limit();
    write_limit(16'd0);
    send_item(CMD_NUM, 16'd5, 1'b1);
    send_item(CMD_BUILD, 16'd0, 1'b1);
    send_item(CMD_NUM, 16'd1, 1'b1);
    send_item(CMD_PRIME, 16'd1, 1'b1);
  endtask

  task automatic test_tiny_limits();
    write_limit(16'd1);
    send_item(CMD_BUILD, 16'h5A5A, 1'b1);
    send_item(CMD_NUM, 16'd1, 1'b1);
    send_item(CMD_NUM, 16'd2, 1'b1);
    send_item(CMD_PRIME, 16'd1, 1'b1);
    write_limit(16'd2);
    send_item(CMD_BUILD, 16'hA5A5, 1'b1);
    send_item(CMD_NUM, 16'd2, 1'b1);
    send_item(CMD_PRIME, 16'd1, 1'b1);
  endtask

  task automatic run_session(input bit gaps);
    int               n;
    int               r;
    logic [1:0]       cmd;
    logic [NUM_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 6) write_limit(NUM_W'($urandom_range(0, 2)));
    else if (r < 12) write_limit(NUM_W'($urandom_range(1000, 4000)));
    else if (r < 90 || limit_reg > 4000) write_limit(NUM_W'($urandom_range(3, 400)));
    send_item(CMD_BUILD, NUM_W'($urandom), gaps);
    if ($urandom_range(0, 7) == 0) write_limit(NUM_W'($urandom));
    n = $urandom_range(10, 60);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        cmd = CMD_NUM;
        idx = pick_index(covered_top);
      end else if (r < 85) begin
        cmd = CMD_PRIME;
        idx = pick_index(prime_cnt);
      end else begin
        cmd = 2'($urandom_range(CMD_NUM, CMD_UNUSED));
        idx = NUM_W'($urandom);
      end
      send_item(cmd, idx, gaps);
    end
  endtask

  task automatic test_random_sessions();
    while (items_sent < RANDOM_ITEMS) run_session($urandom_range(0, 3) != 0);
  endtask

  task automatic test_steady_stream();
    while (items_sent < TOTAL_ITEMS) run_session(1'b0);
  endtask

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    got = {out_status, out_min_factor, out_min_power, out_is_prime,
           out_prime_value, out_prime_count};
    if (rst_n && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: status=%0d", out_status);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("mismatch: expected st=%0d mf=%0d mp=%0d pr=%0b pv=%0d cnt=%0d, %s",
                     want.status, want.min_factor, want.min_power, want.is_prime,
                     want.prime_value, want.prime_count,
                     $sformatf("got st=%0d mf=%0d mp=%0d pr=%0b pv=%0d cnt=%0d",
                               got.status, got.min_factor, got.min_power, got.is_prime,
                               got.prime_value, got.prime_count));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_prebuild_errors();
    test_full_range();
    test_stale_limit();
    test_tiny_limits();
    test_random_sessions();
    test_steady_stream();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
sv/lsmp_pkg.sv
sv/lsmp_ram.sv
sv/lsmp_core.sv
sv/linear_sieve_min_prime_power.sv
bench/linear_sieve_min_prime_power_test.sv
